// ===== src/idw_image_warp_sampler_macros.svh =====
// assertion macros for the image warp sampler checker
`ifndef IDW_IMAGE_WARP_SAMPLER_MACROS_SVH
`define IDW_IMAGE_WARP_SAMPLER_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define IDW_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("idw check failed");

// next-cycle implication, sampled on clock, off during reset
`define IDW_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("idw check failed");

`endif

// ===== src/idw_pkg.sv =====
// shared types, codes and constants of the image warp sampler
`default_nettype none
package idw_pkg;

   localparam int DEF_MAX_POINTS = 16;
   localparam int DEF_MAX_WIDTH  = 256;
   localparam int DEF_MAX_HEIGHT = 256;

   localparam logic [23:0] GRAY_RGB = 24'h7F7F7F;

   localparam int CSR_IW = 2;
   localparam int CSR_DW = 9;
   localparam logic [CSR_IW-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IW-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_IW-1:0] CSR_POINT_COUNT  = 2'd2;

   localparam int WGT_W  = 25;
   localparam int SQ_W   = 17;
   localparam int TERM_W = 11;
   localparam int PROD_W = 37;
   localparam int Q_W    = 19;
   localparam int ICW    = 12;
   localparam int BW_W   = 17;
   localparam int ACC_W  = 25;

   typedef enum logic [1:0] {
      CMD_LOAD_POINT = 2'd0,
      CMD_LOAD_PIXEL = 2'd1,
      CMD_QUERY      = 2'd2
   } req_cmd_type;

   typedef enum logic [2:0] {
      PIX_HIT,
      PIX_BORDER,
      PIX_C0,
      PIX_C1,
      PIX_C2,
      PIX_C3
   } pix_sel_type;

   typedef enum logic [1:0] {
      RES_GRAY,
      RES_PIX,
      RES_BLEND
   } res_sel_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_HIT_RD,
      ST_HIT_CHK,
      ST_HIT_PIX,
      ST_W_RD,
      ST_W_SQRT,
      ST_W_SQRT_WAIT,
      ST_W_DIV_WAIT,
      ST_W_ACC,
      ST_QX_GO,
      ST_QX_WAIT,
      ST_QY_GO,
      ST_QY_WAIT,
      ST_IDENT,
      ST_CLASSIFY,
      ST_BORDER_PIX,
      ST_BL_C1,
      ST_BL_C2,
      ST_BL_C3,
      ST_BL_LAST,
      ST_BL_DONE,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic        capture;
      logic        k_clr;
      logic        k_inc;
      logic        cp_rd;
      logic        sqrt_go;
      logic        wdiv_go;
      logic        mul;
      logic        acc_clr;
      logic        acc;
      logic        qdiv_go;
      logic        q_sel_y;
      logic        q_load;
      logic        q_ident;
      logic        pix_rd;
      pix_sel_type pix_sel;
      logic        bl_clr;
      logic        bl_acc;
      logic        res_load;
      res_sel_type res_sel;
      logic        emit;
   } idw_cmd_type;

   typedef struct packed {
      logic n_zero;
      logic k_last;
      logic hit;
      logic hit_off;
      logic sqrt_done;
      logic div_done;
      logic outside;
      logic border;
      logic out_free;
   } idw_sts_type;

endpackage
`default_nettype wire

// ===== src/idw_sqrt.sv =====
// bit-serial square root of d2 scaled by 2^16, one result bit a cycle
`default_nettype none
module idw_sqrt (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      go,
   input  wire logic [idw_pkg::SQ_W-1:0]  d2,
   output logic                           done,
   output logic [idw_pkg::SQ_W-1:0]       root
);
   import idw_pkg::*;

   localparam int VW  = 2 * SQ_W;
   localparam int RMW = SQ_W + 2;
   localparam int CW  = $clog2(SQ_W);

   logic           busy_ff, done_ff;
   logic [CW-1:0]  cnt_ff;
   logic [VW-1:0]  v_ff, v_in;
   logic [RMW-1:0] rem_ff, rem_in;
   logic [SQ_W-1:0] root_ff, root_in;
   logic [RMW+1:0] rem_n, trial;
   logic           ge;

   always_comb begin
      rem_n   = {rem_ff, v_ff[VW-1:VW-2]};
      trial   = {2'b00, root_ff, 2'b01};
      ge      = rem_n >= trial;
      rem_in  = ge ? RMW'(rem_n - trial) : RMW'(rem_n);
      root_in = {root_ff[SQ_W-2:0], ge};
      v_in    = {v_ff[VW-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (go) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (32'(cnt_ff) == SQ_W - 1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         v_ff    <= {1'b0, d2, 16'b0};
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         v_ff    <= v_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule
`default_nettype wire

// ===== src/idw_div.sv =====
// restoring divider, one quotient bit a cycle, shared by weight and map division
`default_nettype none
module idw_div #(
   parameter int QW  = 50,
   parameter int DVW = 30
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           go,
   input  wire logic [QW-1:0]  num,
   input  wire logic [DVW-1:0] den,
   output logic                done,
   output logic [QW-1:0]       quo,
   output logic [DVW-1:0]      rem
);
   localparam int CW = $clog2(QW);

   logic           busy_ff, done_ff;
   logic [CW-1:0]  cnt_ff;
   logic [QW-1:0]  num_ff, num_in, quo_ff, quo_in;
   logic [DVW-1:0] den_ff, rem_ff, rem_in;
   logic [DVW:0]   r2;
   logic           ge;

   always_comb begin
      r2     = {rem_ff, num_ff[QW-1]};
      ge     = r2 >= {1'b0, den_ff};
      rem_in = ge ? DVW'(r2 - {1'b0, den_ff}) : DVW'(r2);
      quo_in = {quo_ff[QW-2:0], ge};
      num_in = {num_ff[QW-2:0], 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (go) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (32'(cnt_ff) == QW - 1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         num_ff <= num;
         den_ff <= den;
         quo_ff <= '0;
         rem_ff <= '0;
      end else if (busy_ff) begin
         num_ff <= num_in;
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;
   assign rem  = rem_ff;

endmodule
`default_nettype wire

// ===== src/idw_ctrl.sv =====
// sequencer for loads and warp queries
`default_nettype none
module idw_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic [1:0]           req_cmd,
   output logic                      req_stall,
   input  wire idw_pkg::idw_sts_type sts,
   output idw_pkg::idw_cmd_type      cmd
);
   import idw_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               if (req_cmd == CMD_QUERY) begin
                  cmd.k_clr = 1'b1;
                  state_in  = ST_HIT_RD;
               end
            end
         end
         ST_HIT_RD: begin
            if (sts.n_zero) begin
               state_in = ST_IDENT;
            end else begin
               cmd.cp_rd = 1'b1;
               state_in  = ST_HIT_CHK;
            end
         end
         ST_HIT_CHK: begin
            if (sts.hit) begin
               if (sts.hit_off) begin
                  cmd.res_load = 1'b1;
                  cmd.res_sel  = RES_GRAY;
                  state_in     = ST_OUT;
               end else begin
                  cmd.pix_rd  = 1'b1;
                  cmd.pix_sel = PIX_HIT;
                  state_in    = ST_HIT_PIX;
               end
            end else if (sts.k_last) begin
               cmd.k_clr   = 1'b1;
               cmd.acc_clr = 1'b1;
               state_in    = ST_W_RD;
            end else begin
               cmd.k_inc = 1'b1;
               state_in  = ST_HIT_RD;
            end
         end
         ST_HIT_PIX: begin
            cmd.res_load = 1'b1;
            cmd.res_sel  = RES_PIX;
            state_in     = ST_OUT;
         end
         ST_W_RD: begin
            cmd.cp_rd = 1'b1;
            state_in  = ST_W_SQRT;
         end
         ST_W_SQRT: begin
            cmd.sqrt_go = 1'b1;
            state_in    = ST_W_SQRT_WAIT;
         end
         ST_W_SQRT_WAIT: begin
            if (sts.sqrt_done) begin
               cmd.wdiv_go = 1'b1;
               state_in    = ST_W_DIV_WAIT;
            end
         end
         ST_W_DIV_WAIT: begin
            if (sts.div_done) begin
               cmd.mul  = 1'b1;
               state_in = ST_W_ACC;
            end
         end
         ST_W_ACC: begin
            cmd.acc = 1'b1;
            if (sts.k_last) begin
               state_in = ST_QX_GO;
            end else begin
               cmd.k_inc = 1'b1;
               state_in  = ST_W_RD;
            end
         end
         ST_QX_GO: begin
            cmd.qdiv_go = 1'b1;
            state_in    = ST_QX_WAIT;
         end
         ST_QX_WAIT: begin
            if (sts.div_done) begin
               cmd.q_load = 1'b1;
               state_in   = ST_QY_GO;
            end
         end
         ST_QY_GO: begin
            cmd.qdiv_go = 1'b1;
            cmd.q_sel_y = 1'b1;
            state_in    = ST_QY_WAIT;
         end
         ST_QY_WAIT: begin
            cmd.q_sel_y = 1'b1;
            if (sts.div_done) begin
               cmd.q_load = 1'b1;
               state_in   = ST_CLASSIFY;
            end
         end
         ST_IDENT: begin
            cmd.q_ident = 1'b1;
            state_in    = ST_CLASSIFY;
         end
         ST_CLASSIFY: begin
            if (sts.outside) begin
               cmd.res_load = 1'b1;
               cmd.res_sel  = RES_GRAY;
               state_in     = ST_OUT;
            end else if (sts.border) begin
               cmd.pix_rd  = 1'b1;
               cmd.pix_sel = PIX_BORDER;
               state_in    = ST_BORDER_PIX;
            end else begin
               cmd.bl_clr  = 1'b1;
               cmd.pix_rd  = 1'b1;
               cmd.pix_sel = PIX_C0;
               state_in    = ST_BL_C1;
            end
         end
         ST_BORDER_PIX: begin
            cmd.res_load = 1'b1;
            cmd.res_sel  = RES_PIX;
            state_in     = ST_OUT;
         end
         ST_BL_C1: begin
            cmd.bl_acc  = 1'b1;
            cmd.pix_rd  = 1'b1;
            cmd.pix_sel = PIX_C1;
            state_in    = ST_BL_C2;
         end
         ST_BL_C2: begin
            cmd.bl_acc  = 1'b1;
            cmd.pix_rd  = 1'b1;
            cmd.pix_sel = PIX_C2;
            state_in    = ST_BL_C3;
         end
         ST_BL_C3: begin
            cmd.bl_acc  = 1'b1;
            cmd.pix_rd  = 1'b1;
            cmd.pix_sel = PIX_C3;
            state_in    = ST_BL_LAST;
         end
         ST_BL_LAST: begin
            cmd.bl_acc = 1'b1;
            state_in   = ST_BL_DONE;
         end
         ST_BL_DONE: begin
            cmd.res_load = 1'b1;
            cmd.res_sel  = RES_BLEND;
            state_in     = ST_OUT;
         end
         ST_OUT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

// ===== src/idw_datapath.sv =====
// tables, image memory, weight accumulation, mapping and bilinear sampling
`default_nettype none
module idw_datapath #(
   parameter int MAX_POINTS = idw_pkg::DEF_MAX_POINTS,
   parameter int MAX_WIDTH  = idw_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = idw_pkg::DEF_MAX_HEIGHT
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire idw_pkg::idw_cmd_type        cmd,
   output idw_pkg::idw_sts_type             sts,
   input  wire logic [1:0]                  req_cmd,
   input  wire logic [3:0]                  req_point_index,
   input  wire logic [7:0]                  req_origin_x,
   input  wire logic [7:0]                  req_origin_y,
   input  wire logic [7:0]                  req_target_x,
   input  wire logic [7:0]                  req_target_y,
   input  wire logic [7:0]                  req_pixel_x,
   input  wire logic [7:0]                  req_pixel_y,
   input  wire logic [23:0]                 req_pixel_rgb,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [idw_pkg::CSR_IW-1:0]  csr_index,
   input  wire logic [idw_pkg::CSR_DW-1:0]  csr_wdata,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [23:0]                      rsp_out_rgb,
   output logic                             rsp_outside
);
   import idw_pkg::*;

   localparam int PIW       = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int NW        = $clog2(MAX_POINTS + 1);
   localparam int SWW       = WGT_W + NW;
   localparam int NXW       = PROD_W + NW;
   localparam int QW        = NXW + 8;
   localparam int DVW       = SWW;
   localparam int IMG_DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW        = $clog2(IMG_DEPTH);

   // configuration
   logic [8:0]    width_ff, height_ff, w_eff, h_eff;
   logic [4:0]    count_ff;
   logic [NW-1:0] n_eff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 9'd256;
         height_ff <= 9'd256;
         count_ff  <= 5'd0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata;
            CSR_IMAGE_HEIGHT: height_ff <= csr_wdata;
            CSR_POINT_COUNT:  count_ff  <= csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (width_ff == 9'd0) begin
         w_eff = 9'd1;
      end else if (32'(width_ff) > MAX_WIDTH) begin
         w_eff = 9'(MAX_WIDTH);
      end else begin
         w_eff = width_ff;
      end
      if (height_ff == 9'd0) begin
         h_eff = 9'd1;
      end else if (32'(height_ff) > MAX_HEIGHT) begin
         h_eff = 9'(MAX_HEIGHT);
      end else begin
         h_eff = height_ff;
      end
      if (32'(count_ff) > MAX_POINTS) begin
         n_eff = NW'(MAX_POINTS);
      end else begin
         n_eff = NW'(count_ff);
      end
   end

   function automatic logic [AW-1:0] pix_addr(input logic [10:0] cx, input logic [10:0] cy);
      return AW'(32'(cy) * MAX_WIDTH + 32'(cx));
   endfunction

   function automatic logic signed [ICW-1:0] to_int(input logic signed [Q_W-1:0] q);
      logic [Q_W-1:0] qa;
      logic [10:0]    ia;
      qa = q[Q_W-1] ? Q_W'(-q) : Q_W'(q);
      ia = qa[Q_W-1:8];
      return q[Q_W-1] ? -$signed({1'b0, ia}) : $signed({1'b0, ia});
   endfunction

   // query coordinates and point counter
   logic [7:0]     px_ff, py_ff;
   logic [PIW-1:0] k_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         px_ff <= req_pixel_x;
         py_ff <= req_pixel_y;
      end
      if (cmd.k_clr) begin
         k_ff <= '0;
      end else if (cmd.k_inc) begin
         k_ff <= k_ff + 1'b1;
      end
   end

   // control point table
   logic [31:0] cp_mem [MAX_POINTS];
   logic [31:0] cp_rd_ff;
   logic [7:0]  cp_ox, cp_oy, cp_tx, cp_ty;

   always_ff @(posedge clock) begin
      if (cmd.capture && req_cmd == CMD_LOAD_POINT && 32'(req_point_index) < MAX_POINTS) begin
         cp_mem[PIW'(req_point_index)] <= {req_target_y, req_target_x, req_origin_y, req_origin_x};
      end
      if (cmd.cp_rd) begin
         cp_rd_ff <= cp_mem[k_ff];
      end
   end

   assign cp_ox = cp_rd_ff[7:0];
   assign cp_oy = cp_rd_ff[15:8];
   assign cp_tx = cp_rd_ff[23:16];
   assign cp_ty = cp_rd_ff[31:24];

   // distance, weight and sums
   logic [7:0]               adx, ady;
   logic [15:0]              sqx, sqy;
   logic [SQ_W-1:0]          d2, root;
   logic signed [TERM_W-1:0] tx_term, ty_term, tx_term_ff, ty_term_ff;
   logic                     sqrt_done, div_done, div_go;
   logic [QW-1:0]            div_num, quo;
   logic [DVW-1:0]           div_den, rem;
   logic [WGT_W-1:0]         w_ff;
   logic signed [PROD_W-1:0] prodx_ff, prody_ff;
   logic [SWW-1:0]           sw_ff;
   logic signed [NXW-1:0]    nx_ff, ny_ff, n_sel;
   logic [NXW-1:0]           n_abs;

   always_comb begin
      adx     = (px_ff >= cp_tx) ? px_ff - cp_tx : cp_tx - px_ff;
      ady     = (py_ff >= cp_ty) ? py_ff - cp_ty : cp_ty - py_ff;
      sqx     = adx * adx;
      sqy     = ady * ady;
      d2      = {1'b0, sqx} + {1'b0, sqy};
      tx_term = $signed(TERM_W'(cp_ox)) + $signed(TERM_W'(px_ff)) - $signed(TERM_W'(cp_tx));
      ty_term = $signed(TERM_W'(cp_oy)) + $signed(TERM_W'(py_ff)) - $signed(TERM_W'(cp_ty));
      n_sel   = cmd.q_sel_y ? ny_ff : nx_ff;
      n_abs   = n_sel[NXW-1] ? NXW'(-n_sel) : NXW'(n_sel);
      div_go  = cmd.wdiv_go || cmd.qdiv_go;
      if (cmd.wdiv_go) begin
         div_num = {{(QW-33){1'b0}}, 1'b1, 32'b0};
         div_den = DVW'(root);
      end else begin
         div_num = {n_abs, 8'b0};
         div_den = sw_ff;
      end
   end

   idw_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .go    (cmd.sqrt_go),
      .d2    (d2),
      .done  (sqrt_done),
      .root  (root)
   );

   idw_div #(
      .QW  (QW),
      .DVW (DVW)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .go    (div_go),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (quo),
      .rem   (rem)
   );

   always_ff @(posedge clock) begin
      if (cmd.sqrt_go) begin
         tx_term_ff <= tx_term;
         ty_term_ff <= ty_term;
      end
      if (cmd.mul) begin
         w_ff     <= quo[WGT_W-1:0];
         prodx_ff <= $signed({1'b0, quo[WGT_W-1:0]}) * tx_term_ff;
         prody_ff <= $signed({1'b0, quo[WGT_W-1:0]}) * ty_term_ff;
      end
      if (cmd.acc_clr) begin
         sw_ff <= '0;
         nx_ff <= '0;
         ny_ff <= '0;
      end else if (cmd.acc) begin
         sw_ff <= sw_ff + SWW'(w_ff);
         nx_ff <= nx_ff + NXW'(prodx_ff);
         ny_ff <= ny_ff + NXW'(prody_ff);
      end
   end

   // mapped coordinate, floor division
   logic [Q_W-1:0]         q_mag;
   logic signed [Q_W-1:0]  q_val, qx_ff, qy_ff;

   always_comb begin
      q_mag = quo[Q_W-1:0];
      if (n_sel[NXW-1]) begin
         q_val = -$signed(q_mag) - $signed(Q_W'(rem != '0));
      end else begin
         q_val = $signed(q_mag);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.q_ident) begin
         qx_ff <= $signed({3'b000, px_ff, 8'b0});
         qy_ff <= $signed({3'b000, py_ff, 8'b0});
      end else if (cmd.q_load) begin
         if (cmd.q_sel_y) begin
            qy_ff <= q_val;
         end else begin
            qx_ff <= q_val;
         end
      end
   end

   // classification
   logic signed [ICW-1:0] ix, iy, wi, hi;
   logic [10:0]           x0, y0, x1, y1;

   always_comb begin
      ix = to_int(qx_ff);
      iy = to_int(qy_ff);
      wi = $signed({3'b000, w_eff});
      hi = $signed({3'b000, h_eff});
      x0 = ix[10:0];
      y0 = iy[10:0];
      x1 = x0 + 11'd1;
      y1 = y0 + 11'd1;
   end

   assign sts.outside = (ix < 0) || (ix >= wi) || (iy < 0) || (iy >= hi);
   assign sts.border  = (ix == 0) || (ix == wi - 1) || (iy == 0) || (iy == hi - 1);

   // source image and sampling
   logic [23:0]      img_mem [IMG_DEPTH];
   logic [23:0]      img_rd_ff;
   logic [AW-1:0]    rd_addr;
   logic [8:0]       ax, ay, fxe, fye, wa, wb;
   logic [17:0]      bw_prod;
   logic [BW_W-1:0]  bw_ff;
   logic [ACC_W-1:0] acc_r_ff, acc_g_ff, acc_b_ff;

   always_comb begin
      fxe = {1'b0, qx_ff[7:0]};
      fye = {1'b0, qy_ff[7:0]};
      ax  = 9'd256 - fxe;
      ay  = 9'd256 - fye;
      case (cmd.pix_sel)
         PIX_HIT: begin
            rd_addr = pix_addr({3'b000, cp_ox}, {3'b000, cp_oy});
            wa = ax;
            wb = ay;
         end
         PIX_BORDER: begin
            rd_addr = pix_addr(x0, y0);
            wa = ax;
            wb = ay;
         end
         PIX_C0: begin
            rd_addr = pix_addr(x0, y0);
            wa = ax;
            wb = ay;
         end
         PIX_C1: begin
            rd_addr = pix_addr(x1, y0);
            wa = fxe;
            wb = ay;
         end
         PIX_C2: begin
            rd_addr = pix_addr(x0, y1);
            wa = ax;
            wb = fye;
         end
         PIX_C3: begin
            rd_addr = pix_addr(x1, y1);
            wa = fxe;
            wb = fye;
         end
         default: begin
            rd_addr = pix_addr(x0, y0);
            wa = ax;
            wb = ay;
         end
      endcase
      bw_prod = wa * wb;
   end

   always_ff @(posedge clock) begin
      if (cmd.capture && req_cmd == CMD_LOAD_PIXEL
          && 32'(req_pixel_x) < MAX_WIDTH && 32'(req_pixel_y) < MAX_HEIGHT) begin
         img_mem[pix_addr({3'b000, req_pixel_x}, {3'b000, req_pixel_y})] <= req_pixel_rgb;
      end
      if (cmd.pix_rd) begin
         img_rd_ff <= img_mem[rd_addr];
         bw_ff     <= bw_prod[BW_W-1:0];
      end
      if (cmd.bl_clr) begin
         acc_r_ff <= '0;
         acc_g_ff <= '0;
         acc_b_ff <= '0;
      end else if (cmd.bl_acc) begin
         acc_r_ff <= acc_r_ff + bw_ff * img_rd_ff[23:16];
         acc_g_ff <= acc_g_ff + bw_ff * img_rd_ff[15:8];
         acc_b_ff <= acc_b_ff + bw_ff * img_rd_ff[7:0];
      end
   end

   // result and output register
   logic [23:0] res_rgb_ff, rsp_rgb_ff;
   logic        res_out_ff, rsp_out_ff, rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (cmd.res_load) begin
         case (cmd.res_sel)
            RES_GRAY: begin
               res_rgb_ff <= GRAY_RGB;
               res_out_ff <= 1'b1;
            end
            RES_PIX: begin
               res_rgb_ff <= img_rd_ff;
               res_out_ff <= 1'b0;
            end
            RES_BLEND: begin
               res_rgb_ff <= {acc_r_ff[23:16], acc_g_ff[23:16], acc_b_ff[23:16]};
               res_out_ff <= 1'b0;
            end
            default: begin
               res_rgb_ff <= GRAY_RGB;
               res_out_ff <= 1'b1;
            end
         endcase
      end
      if (cmd.emit) begin
         rsp_rgb_ff <= res_rgb_ff;
         rsp_out_ff <= res_out_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_out_rgb = rsp_rgb_ff;
   assign rsp_outside = rsp_out_ff;

   assign sts.n_zero    = (n_eff == '0);
   assign sts.k_last    = (32'(k_ff) + 32'd1 == 32'(n_eff));
   assign sts.hit       = (cp_tx == px_ff) && (cp_ty == py_ff);
   assign sts.hit_off   = ({1'b0, cp_ox} >= w_eff) || ({1'b0, cp_oy} >= h_eff);
   assign sts.sqrt_done = sqrt_done;
   assign sts.div_done  = div_done;
   assign sts.out_free  = !rsp_valid_ff || !rsp_stall;

endmodule
`default_nettype wire

// ===== src/idw_image_warp_sampler.sv =====
// Image warp sampler top level. Load transactions (control pair or source pixel) are taken
// without a stall. A query's run time grows with the number n of active control pairs and
// with QW, the divider width (50 with the default of 16 pairs); it is set by the single
// shared bit-serial divider, which forms each 1/distance weight and both mapped coordinates,
// and by the bit-serial square root per pair. An exact target hit ends the query at the
// matching table entry, before any weight is formed. One transaction is worked on at a time;
// a finished result waits in the output register while the next transaction is taken.
// Configuration writes are always accepted.
`default_nettype none
module idw_image_warp_sampler #(
   parameter int MAX_POINTS = idw_pkg::DEF_MAX_POINTS,
   parameter int MAX_WIDTH  = idw_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = idw_pkg::DEF_MAX_HEIGHT
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [1:0]                  req_cmd,
   input  wire logic [3:0]                  req_point_index,
   input  wire logic [7:0]                  req_origin_x,
   input  wire logic [7:0]                  req_origin_y,
   input  wire logic [7:0]                  req_target_x,
   input  wire logic [7:0]                  req_target_y,
   input  wire logic [7:0]                  req_pixel_x,
   input  wire logic [7:0]                  req_pixel_y,
   input  wire logic [23:0]                 req_pixel_rgb,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [23:0]                      rsp_out_rgb,
   output logic                             rsp_outside,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [idw_pkg::CSR_IW-1:0]  csr_index,
   input  wire logic [idw_pkg::CSR_DW-1:0]  csr_wdata
);
   import idw_pkg::*;

   idw_cmd_type cmd;
   idw_sts_type sts;

   idw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   idw_datapath #(
      .MAX_POINTS (MAX_POINTS),
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_cmd         (req_cmd),
      .req_point_index (req_point_index),
      .req_origin_x    (req_origin_x),
      .req_origin_y    (req_origin_y),
      .req_target_x    (req_target_x),
      .req_target_y    (req_target_y),
      .req_pixel_x     (req_pixel_x),
      .req_pixel_y     (req_pixel_y),
      .req_pixel_rgb   (req_pixel_rgb),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_rgb     (rsp_out_rgb),
      .rsp_outside     (rsp_outside)
   );

endmodule
`default_nettype wire

// ===== src/idw_checker.sv =====
// port-level checks of the image warp sampler and their bind
`default_nettype none
`include "idw_image_warp_sampler_macros.svh"
module idw_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic [1:0]  req_cmd,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [23:0] rsp_out_rgb,
   input wire logic        rsp_outside
);
   import idw_pkg::*;

   logic req_take, req_load;

   assign req_take = req_valid && !req_stall;
   assign req_load = req_take && (req_cmd == CMD_LOAD_POINT || req_cmd == CMD_LOAD_PIXEL);

   // a query holds off further transactions while it runs
   `IDW_ASSERT_NEXT(a_query_busy, req_take && req_cmd == CMD_QUERY, req_stall)

   // a load leaves the request port unstalled after it is taken
   `IDW_ASSERT_NEXT(a_load_quick, req_load, !req_stall)

   // outside flag always comes with gray
   `IDW_ASSERT_NOW(a_outside_gray, rsp_valid && rsp_outside, rsp_out_rgb == GRAY_RGB)

   // stalled result stays offered
   `IDW_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid)

endmodule

bind idw_image_warp_sampler idw_checker u_idw_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_cmd     (req_cmd),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_out_rgb (rsp_out_rgb),
   .rsp_outside (rsp_outside)
);
`default_nettype wire

// ===== tb/testbench.sv =====
// self-checking testbench for the image warp sampler: queued stimulus, shadow predictor
`timescale 1ns / 1ps
`default_nettype none
module testbench;
   import idw_pkg::*;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int HOLD_CYCLES = 4000;
   localparam longint CYCLE_LIMIT = 6000000;

   typedef struct {
      logic [1:0]  cmd;
      logic [3:0]  slot;
      logic [7:0]  ox, oy, tx, ty, px, py;
      logic [23:0] rgb;
   } warp_txn_type;

   typedef struct {
      logic [23:0] rgb;
      logic        outside;
   } pixel_result_type;

   typedef struct {
      logic [7:0] ox, oy, tx, ty;
   } ctrl_pair_type;

   logic        clock, reset;
   logic        req_valid, req_stall;
   logic [1:0]  req_cmd;
   logic [3:0]  req_point_index;
   logic [7:0]  req_origin_x, req_origin_y, req_target_x, req_target_y;
   logic [7:0]  req_pixel_x, req_pixel_y;
   logic [23:0] req_pixel_rgb;
   logic        rsp_valid, rsp_stall;
   logic [23:0] rsp_out_rgb;
   logic        rsp_outside;
   logic        csr_valid, csr_ready;
   logic [CSR_IW-1:0] csr_index;
   logic [CSR_DW-1:0] csr_wdata;

   warp_txn_type     pending_txns[$];
   pixel_result_type expected_pixels[$];
   int               error_count = 0;
   longint           cycle_count = 0;
   int               long_hold_requests = 0;

   ctrl_pair_type pair_table[16];
   logic [23:0]   src_image[65536];
   bit            pixel_written[65536];
   int            shadow_width = 256, shadow_height = 256, shadow_count = 0;

   idw_image_warp_sampler i_dut (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      $display("mismatch: %s", what);
      error_count++;
   endtask

   function automatic longint floor_div(input longint a, input longint b);
      longint t;
      t = a / b;
      if ((a % b) != 0 && a < 0) t -= 1;
      return t;
   endfunction

   function automatic longint int_sqrt(input longint v);
      longint r;
      r = 0;
      for (int b = 20; b >= 0; b--)
         if ((r + (longint'(1) << b)) * (r + (longint'(1) << b)) <= v) r += longint'(1) << b;
      return r;
   endfunction

   // maps a query pixel backward and lists the source pixels the sample needs
   function automatic void map_query(input logic [7:0] x, input logic [7:0] y,
                                     output pixel_result_type res, output int nreads,
                                     output int rd_x[4], output int rd_y[4],
                                     output longint qx, output longint qy);
      longint w, h, n, sw, nx, ny, ix, iy, dx, dy, root_q8, wt;
      w = shadow_width < 1 ? 1 : (shadow_width > 256 ? 256 : shadow_width);
      h = shadow_height < 1 ? 1 : (shadow_height > 256 ? 256 : shadow_height);
      n = shadow_count > 16 ? 16 : shadow_count;
      nreads = 0;
      res.rgb = GRAY_RGB;
      res.outside = 1'b1;
      qx = 0;
      qy = 0;
      for (int k = 0; k < n; k++)
         if (pair_table[k].tx == x && pair_table[k].ty == y) begin
            if (pair_table[k].ox < w && pair_table[k].oy < h) begin
               res.outside = 1'b0;
               nreads = 1;
               rd_x[0] = int'(pair_table[k].ox);
               rd_y[0] = int'(pair_table[k].oy);
            end
            return;
         end
      if (n == 0) begin
         qx = longint'(x) * 256;
         qy = longint'(y) * 256;
      end else begin
         sw = 0; nx = 0; ny = 0;
         for (int k = 0; k < n; k++) begin
            dx = longint'(x) - pair_table[k].tx;
            dy = longint'(y) - pair_table[k].ty;
            root_q8 = int_sqrt((dx * dx + dy * dy) * 65536);
            wt = (longint'(1) << 32) / root_q8;
            sw += wt;
            nx += wt * (longint'(pair_table[k].ox) + x - pair_table[k].tx);
            ny += wt * (longint'(pair_table[k].oy) + y - pair_table[k].ty);
         end
         qx = floor_div(nx * 256, sw);
         qy = floor_div(ny * 256, sw);
      end
      ix = qx >= 0 ? qx / 256 : -((-qx) / 256);
      iy = qy >= 0 ? qy / 256 : -((-qy) / 256);
      if (ix < 0 || ix >= w || iy < 0 || iy >= h) return;
      res.outside = 1'b0;
      if (ix == 0 || ix == w - 1 || iy == 0 || iy == h - 1) begin
         nreads = 1;
         rd_x[0] = int'(ix);
         rd_y[0] = int'(iy);
      end else begin
         nreads = 4;
         for (int c = 0; c < 4; c++) begin
            rd_x[c] = int'(qx / 256 + c % 2);
            rd_y[c] = int'(qy / 256 + c / 2);
         end
      end
   endfunction

   function automatic logic [23:0] blend(input int rd_x[4], input int rd_y[4],
                                         input longint qx, input longint qy);
      longint fx, fy, s;
      longint wgt[4];
      logic [23:0] c;
      logic [23:0] out;
      fx = qx % 256;
      fy = qy % 256;
      wgt[0] = (256 - fx) * (256 - fy);
      wgt[1] = fx * (256 - fy);
      wgt[2] = (256 - fx) * fy;
      wgt[3] = fx * fy;
      out = '0;
      for (int sh = 0; sh < 24; sh += 8) begin
         s = 0;
         for (int k = 0; k < 4; k++) begin
            c = src_image[rd_y[k] * 256 + rd_x[k]];
            s += wgt[k] * longint'((c >> sh) & 24'hFF);
         end
         out = out | 24'(((s >> 16) & 255) << sh);
      end
      return out;
   endfunction

   task automatic queue_txn(input warp_txn_type t);
      if (t.cmd == CMD_LOAD_POINT) begin
         pair_table[t.slot] = '{t.ox, t.oy, t.tx, t.ty};
      end else if (t.cmd == CMD_LOAD_PIXEL) begin
         src_image[t.py * 256 + t.px] = t.rgb;
         pixel_written[t.py * 256 + t.px] = 1'b1;
      end
      pending_txns = {pending_txns, t};
   endtask

   function automatic warp_txn_type random_txn(input logic [1:0] cmd);
      warp_txn_type t;
      t.cmd = cmd;
      t.slot = 4'($urandom);
      t.ox = 8'($urandom); t.oy = 8'($urandom); t.tx = 8'($urandom); t.ty = 8'($urandom);
      t.px = 8'($urandom); t.py = 8'($urandom);
      t.rgb = 24'($urandom);
      return t;
   endfunction

   // queues a query, loading any source pixel it will read that was never written
   task automatic queue_query(input logic [7:0] x, input logic [7:0] y);
      pixel_result_type res;
      int nreads;
      int rd_x[4], rd_y[4];
      longint qx, qy;
      warp_txn_type t;
      map_query(x, y, res, nreads, rd_x, rd_y, qx, qy);
      for (int k = 0; k < nreads; k++)
         if (!pixel_written[rd_y[k] * 256 + rd_x[k]]) begin
            t = random_txn(CMD_LOAD_PIXEL);
            t.px = 8'(rd_x[k]);
            t.py = 8'(rd_y[k]);
            queue_txn(t);
         end
      if (nreads == 1) res.rgb = src_image[rd_y[0] * 256 + rd_x[0]];
      else if (nreads == 4) res.rgb = blend(rd_x, rd_y, qx, qy);
      t = random_txn(CMD_QUERY);
      t.px = x;
      t.py = y;
      pending_txns = {pending_txns, t};
      expected_pixels = {expected_pixels, res};
   endtask

   task automatic wait_drained();
      while (pending_txns.size() > 0 || req_valid || expected_pixels.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IW-1:0] idx, input int value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DW'(value);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_IMAGE_WIDTH) shadow_width = value;
      else if (idx == CSR_IMAGE_HEIGHT) shadow_height = value;
      else shadow_count = value;
   endtask

   function automatic logic [7:0] pick_coord(input int size);
      int lim;
      lim = size < 1 ? 1 : (size > 256 ? 256 : size);
      case ($urandom_range(0, 5))
         0: return 8'd0;
         1: return 8'(lim - 1);
         2: return 8'($urandom);
         default: return 8'($urandom_range(0, lim + 1 > 255 ? 255 : lim + 1));
      endcase
   endfunction

   initial begin
      int phase_w[9] = '{256, 256, 1, 0, 511, 16, 256, 40, 2};
      int phase_h[9] = '{256, 256, 1, 0, 300, 12, 256, 200, 2};
      int phase_n[9] = '{0, 16, 4, 31, 17, 3, 1, 8, 2};
      warp_txn_type t;
      int k, lim_w, lim_h;
      csr_valid = 1'b0;
      csr_index = CSR_IMAGE_WIDTH;
      csr_wdata = '0;
      @(negedge reset);
      // every slot written first so no query reads an empty table entry
      for (k = 0; k < 16; k++) begin
         t = random_txn(CMD_LOAD_POINT);
         t.slot = 4'(k);
         if (k == 0) begin t.ox = 8'd0; t.oy = 8'd255; t.tx = 8'd255; t.ty = 8'd0; end
         if (k == 1) begin t.ox = 8'd255; t.oy = 8'd0; t.tx = 8'd0; t.ty = 8'd255; end
         queue_txn(t);
      end
      t = random_txn(CMD_LOAD_PIXEL);
      t.px = 8'd255; t.py = 8'd255; t.rgb = 24'hFFFFFF;
      queue_txn(t);
      t = random_txn(CMD_UNUSED);
      pending_txns = {pending_txns, t};
      queue_query(8'd0, 8'd0);
      queue_query(8'd255, 8'd255);
      queue_query(8'd128, 8'd77);
      wait_drained();
      for (int p = 0; p < 9; p++) begin
         write_csr(CSR_IMAGE_WIDTH, phase_w[p]);
         write_csr(CSR_IMAGE_HEIGHT, phase_h[p]);
         write_csr(CSR_POINT_COUNT, phase_n[p]);
         if (p == 1) begin
            queue_query(pair_table[0].tx, pair_table[0].ty);
            queue_query(pair_table[1].tx, pair_table[1].ty);
            queue_query(8'd3, 8'd200);
            long_hold_requests++;
         end
         lim_w = phase_w[p];
         lim_h = phase_h[p];
         repeat (p == 1 ? 16 : 28) begin
            case ($urandom_range(0, 9))
               0: queue_txn(random_txn(CMD_LOAD_POINT));
               1: queue_txn(random_txn(CMD_LOAD_PIXEL));
               2: pending_txns = {pending_txns, random_txn(CMD_UNUSED)};
               3: begin
                  k = $urandom_range(0, 15);
                  queue_query(pair_table[k].tx, pair_table[k].ty);
               end
               4: begin
                  t = random_txn(CMD_LOAD_POINT);
                  t.slot = 4'($urandom_range(0, 3));
                  t.ox = pick_coord(lim_w); t.oy = pick_coord(lim_h);
                  t.tx = pick_coord(lim_w); t.ty = pick_coord(lim_h);
                  queue_txn(t);
               end
               default: queue_query(pick_coord(lim_w), pick_coord(lim_h));
            endcase
         end
         wait_drained();
      end
      wait_drained();
      if (error_count == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

   int gap_left, burst_left;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_cmd <= CMD_QUERY;
         req_point_index <= '0;
         {req_origin_x, req_origin_y, req_target_x, req_target_y} <= '0;
         {req_pixel_x, req_pixel_y} <= '0;
         req_pixel_rgb <= '0;
         gap_left <= 0;
         burst_left <= 0;
      end else if (!req_valid || !req_stall) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_txns.size() > 0) begin
            warp_txn_type t;
            t = pending_txns.pop_front();
            req_valid <= 1'b1;
            req_cmd <= t.cmd;
            req_point_index <= t.slot;
            req_origin_x <= t.ox;
            req_origin_y <= t.oy;
            req_target_x <= t.tx;
            req_target_y <= t.ty;
            req_pixel_x <= t.px;
            req_pixel_y <= t.py;
            req_pixel_rgb <= t.rgb;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 16);
               gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   int hold_left, holds_done, stall_mode, mode_left;
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
         holds_done <= 0;
         stall_mode <= 0;
         mode_left <= 0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= hold_left > 1;
      end else if (holds_done < long_hold_requests) begin
         holds_done <= holds_done + 1;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            mode_left <= $urandom_range(8, 80);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= $urandom_range(0, 3) == 0;
            default: rsp_stall <= $urandom_range(0, 3) != 0;
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_pixels.size() == 0) begin
            report_mismatch("result with no query outstanding");
         end else begin
            pixel_result_type e;
            e = expected_pixels.pop_front();
            if (rsp_out_rgb !== e.rgb)
               report_mismatch($sformatf("out_rgb %h expected %h", rsp_out_rgb, e.rgb));
            if (rsp_outside !== e.outside)
               report_mismatch($sformatf("outside %b expected %b", rsp_outside, e.outside));
         end
      end
   end

endmodule
`default_nettype wire
